// ----- rtl/core/trd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

	// Fixed field widths of the words on the ports.
	localparam int COORD_W = 16;
	localparam int DEPTH_W = 32;
	localparam int COLOR_W = 16;
	localparam int COUNT_W = 17;
	localparam int PIXEL_W = 8;
	localparam int CFG_DATA_W = 9;
	localparam int CFG_INDEX_W = 2;

	// Widths of the command between front and back, sized for the largest
	// frame (4096 x 4096) and the largest number of fraction bits (8).
	localparam int DIFF_W = COORD_W + 1;
	localparam int POS_W = 12;
	localparam int ADDR_W = 24;
	localparam int EDGE_W = 40;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] ACT_DRAW = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;

	typedef struct packed {
		logic [1:0] action;
		logic signed [COORD_W-1:0] vert0_x;
		logic signed [COORD_W-1:0] vert0_y;
		logic signed [COORD_W-1:0] vert1_x;
		logic signed [COORD_W-1:0] vert1_y;
		logic signed [COORD_W-1:0] vert2_x;
		logic signed [COORD_W-1:0] vert2_y;
		logic signed [DEPTH_W-1:0] depth_value;
		logic [COLOR_W-1:0] color_value;
		logic [PIXEL_W-1:0] pixel_col;
		logic [PIXEL_W-1:0] pixel_row;
	} in_word_t;

	typedef struct packed {
		logic signed [DEPTH_W-1:0] read_depth;
		logic [COLOR_W-1:0] read_color;
		logic [COUNT_W-1:0] pixels_written;
	} out_word_t;

	typedef enum logic [1:0] {
		CMD_NOP,
		CMD_DRAW,
		CMD_WRITE,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [ADDR_W-1:0] addr;
		logic [POS_W-1:0] u_start;
		logic [POS_W-1:0] u_end;
		logic [POS_W-1:0] v_start;
		logic [POS_W-1:0] v_end;
		logic signed [EDGE_W-1:0] area;
		logic signed [EDGE_W-1:0] edge_a;
		logic signed [EDGE_W-1:0] edge_b;
		logic signed [DIFF_W-1:0] e1x;
		logic signed [DIFF_W-1:0] e1y;
		logic signed [DIFF_W-1:0] e2x;
		logic signed [DIFF_W-1:0] e2y;
		logic signed [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] color;
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_BOX,
		F_ORG,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_RWAIT,
		B_RDATA,
		B_PIX,
		B_CHK,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/trd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trd_front #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int COORD_FRAC_BITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire trd_pkg::in_word_t in_word,
	input wire logic [$clog2(MAX_WIDTH+1)-1:0] width_eff,
	input wire logic [$clog2(MAX_HEIGHT+1)-1:0] height_eff,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output trd_pkg::cmd_t cmd
);

	localparam int F = COORD_FRAC_BITS;
	localparam int CBW = $clog2(MAX_WIDTH);
	localparam int CBH = $clog2(MAX_HEIGHT);
	localparam int CB = (CBW > CBH) ? CBW : CBH;
	localparam int PW = ((CB + F > 16) ? CB + F : 16) + 2;
	localparam int OBW = trd_pkg::DIFF_W + 1;
	localparam int PRW = PW + OBW;
	localparam int BW = 18;
	localparam int EW = trd_pkg::EDGE_W;
	localparam int AW = trd_pkg::ADDR_W;
	localparam logic [2:0] MUL_LAST = 3'd6;
	localparam logic signed [BW-1:0] ROUND_UP = BW'((1 << F) - 1);

	trd_pkg::front_state_t state_q, state_d;
	logic [2:0] cnt_q;

	trd_pkg::in_word_t in_q;
	logic signed [trd_pkg::DIFF_W-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
	logic [trd_pkg::POS_W-1:0] u_start_q, u_end_q, v_start_q, v_end_q;
	logic empty_q, in_frame_q;
	logic [AW-1:0] addr_q;
	logic signed [PW-1:0] px_q, py_q;
	logic signed [EW-1:0] p_q, area_q, a_q, b_q;

	function automatic logic signed [trd_pkg::COORD_W-1:0] min3(
		input logic signed [trd_pkg::COORD_W-1:0] p,
		input logic signed [trd_pkg::COORD_W-1:0] q,
		input logic signed [trd_pkg::COORD_W-1:0] r);
		logic signed [trd_pkg::COORD_W-1:0] m;
		m = (p < q) ? p : q;
		return (m < r) ? m : r;
	endfunction

	function automatic logic signed [trd_pkg::COORD_W-1:0] max3(
		input logic signed [trd_pkg::COORD_W-1:0] p,
		input logic signed [trd_pkg::COORD_W-1:0] q,
		input logic signed [trd_pkg::COORD_W-1:0] r);
		logic signed [trd_pkg::COORD_W-1:0] m;
		m = (p > q) ? p : q;
		return (m > r) ? m : r;
	endfunction

	// Bounding box, clamped to the frame.
	logic signed [trd_pkg::COORD_W-1:0] xmin, xmax, ymin, ymax;
	logic signed [BW-1:0] umin_r, umax_r, vmin_r, vmax_r;
	logic signed [BW-1:0] umin_c, umax_c, vmin_c, vmax_c, wm1, hm1;
	logic box_empty;
	logic [AW-1:0] pix_addr;
	logic pix_in_frame;

	always_comb begin
		xmin = min3(in_q.vert0_x, in_q.vert1_x, in_q.vert2_x);
		xmax = max3(in_q.vert0_x, in_q.vert1_x, in_q.vert2_x);
		ymin = min3(in_q.vert0_y, in_q.vert1_y, in_q.vert2_y);
		ymax = max3(in_q.vert0_y, in_q.vert1_y, in_q.vert2_y);
		umin_r = (BW'(xmin) + ROUND_UP) >>> F;
		vmin_r = (BW'(ymin) + ROUND_UP) >>> F;
		umax_r = BW'(xmax) >>> F;
		vmax_r = BW'(ymax) >>> F;
		wm1 = $signed(BW'(width_eff)) - BW'(1);
		hm1 = $signed(BW'(height_eff)) - BW'(1);
		umin_c = (umin_r < 0) ? '0 : umin_r;
		vmin_c = (vmin_r < 0) ? '0 : vmin_r;
		umax_c = (umax_r > wm1) ? wm1 : umax_r;
		vmax_c = (vmax_r > hm1) ? hm1 : vmax_r;
		box_empty = (umax_c < umin_c) || (vmax_c < vmin_c);
		pix_addr = AW'(in_q.pixel_row) * AW'(width_eff) + AW'(in_q.pixel_col);
		pix_in_frame = (32'(in_q.pixel_col) < 32'(width_eff)) &&
			(32'(in_q.pixel_row) < 32'(height_eff));
	end

	// One multiplier, shared over the six products of the set-up.
	logic signed [PW-1:0] op_a;
	logic signed [OBW-1:0] op_b;
	logic signed [PRW-1:0] prod;

	always_comb begin
		case (cnt_q)
			3'd0: begin
				op_a = PW'(e1x_q);
				op_b = OBW'(e2y_q);
			end
			3'd1: begin
				op_a = PW'(e1y_q);
				op_b = OBW'(e2x_q);
			end
			3'd2: begin
				op_a = px_q;
				op_b = OBW'(e2y_q);
			end
			3'd3: begin
				op_a = py_q;
				op_b = OBW'(e2x_q);
			end
			3'd4: begin
				op_a = py_q;
				op_b = OBW'(e1x_q);
			end
			default: begin
				op_a = px_q;
				op_b = OBW'(e1y_q);
			end
		endcase
		prod = op_a * op_b;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			trd_pkg::F_IDLE: begin
				if (push) state_d = trd_pkg::F_BOX;
			end
			trd_pkg::F_BOX: begin
				if (in_q.action == trd_pkg::ACT_DRAW) state_d = trd_pkg::F_ORG;
				else state_d = trd_pkg::F_PUSH;
			end
			trd_pkg::F_ORG: begin
				state_d = trd_pkg::F_MUL;
			end
			trd_pkg::F_MUL: begin
				if (cnt_q == MUL_LAST) state_d = trd_pkg::F_PUSH;
			end
			trd_pkg::F_PUSH: begin
				if (cmd_ready) state_d = trd_pkg::F_IDLE;
			end
			default: begin
				state_d = trd_pkg::F_IDLE;
			end
		endcase
	end

	always_comb begin
		full = (state_q != trd_pkg::F_IDLE);
		cmd_valid = (state_q == trd_pkg::F_PUSH);
		cmd.kind = trd_pkg::CMD_NOP;
		case (in_q.action)
			trd_pkg::ACT_DRAW: begin
				if (!empty_q && area_q != '0) cmd.kind = trd_pkg::CMD_DRAW;
			end
			trd_pkg::ACT_WRITE: begin
				if (in_frame_q) cmd.kind = trd_pkg::CMD_WRITE;
			end
			trd_pkg::ACT_READ: begin
				if (in_frame_q) cmd.kind = trd_pkg::CMD_READ;
			end
			default: begin
				cmd.kind = trd_pkg::CMD_NOP;
			end
		endcase
		cmd.addr = addr_q;
		cmd.u_start = u_start_q;
		cmd.u_end = u_end_q;
		cmd.v_start = v_start_q;
		cmd.v_end = v_end_q;
		cmd.area = area_q;
		cmd.edge_a = a_q;
		cmd.edge_b = b_q;
		cmd.e1x = e1x_q;
		cmd.e1y = e1y_q;
		cmd.e2x = e2x_q;
		cmd.e2y = e2y_q;
		cmd.depth = in_q.depth_value;
		cmd.color = in_q.color_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trd_pkg::F_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == trd_pkg::F_MUL) cnt_q <= cnt_q + 3'd1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == trd_pkg::F_IDLE && push) in_q <= in_word;
		if (state_q == trd_pkg::F_BOX) begin
			e1x_q <= trd_pkg::DIFF_W'(in_q.vert1_x) - trd_pkg::DIFF_W'(in_q.vert0_x);
			e1y_q <= trd_pkg::DIFF_W'(in_q.vert1_y) - trd_pkg::DIFF_W'(in_q.vert0_y);
			e2x_q <= trd_pkg::DIFF_W'(in_q.vert2_x) - trd_pkg::DIFF_W'(in_q.vert0_x);
			e2y_q <= trd_pkg::DIFF_W'(in_q.vert2_y) - trd_pkg::DIFF_W'(in_q.vert0_y);
			u_start_q <= umin_c[trd_pkg::POS_W-1:0];
			u_end_q <= umax_c[trd_pkg::POS_W-1:0];
			v_start_q <= vmin_c[trd_pkg::POS_W-1:0];
			v_end_q <= vmax_c[trd_pkg::POS_W-1:0];
			empty_q <= box_empty;
			in_frame_q <= pix_in_frame;
			addr_q <= pix_addr;
		end
		if (state_q == trd_pkg::F_ORG) begin
			px_q <= $signed(PW'(u_start_q) << F) - PW'(in_q.vert0_x);
			py_q <= $signed(PW'(v_start_q) << F) - PW'(in_q.vert0_y);
			addr_q <= AW'(v_start_q) * AW'(width_eff) + AW'(u_start_q);
		end
		if (state_q == trd_pkg::F_MUL) begin
			p_q <= EW'(prod);
			case (cnt_q)
				3'd1: area_q <= p_q;
				3'd2: area_q <= area_q - p_q;
				3'd3: a_q <= p_q;
				3'd4: a_q <= a_q - p_q;
				3'd5: b_q <= p_q;
				3'd6: b_q <= b_q - p_q;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/trd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trd_queue #(
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire trd_pkg::cmd_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output trd_pkg::cmd_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	trd_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = slot_q[rptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
			if (do_rd) rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PTR_W'(1);
			if (do_wr && !do_rd) count_q <= count_q + CNT_W'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) slot_q[wptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

// ----- rtl/core/trd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module trd_back #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int COORD_FRAC_BITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire trd_pkg::cmd_t cmd,
	input wire logic [$clog2(MAX_WIDTH+1)-1:0] width_eff,
	output logic res_valid,
	input wire logic res_ready,
	output trd_pkg::out_word_t res
);

	localparam int F = COORD_FRAC_BITS;
	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int EW = trd_pkg::EDGE_W;
	localparam int SW = EW + 1;

	trd_pkg::back_state_t state_q, state_d;
	trd_pkg::cmd_t cmd_q;
	logic [trd_pkg::POS_W-1:0] u_q, v_q;
	logic [AW-1:0] addr_q, col_addr_q;
	logic signed [EW-1:0] a_q, b_q, acol_q, bcol_q;
	logic [trd_pkg::COUNT_W-1:0] cnt_q;
	logic signed [trd_pkg::DEPTH_W-1:0] rdep_q;
	logic [trd_pkg::COLOR_W-1:0] rcol_q;

	logic [trd_pkg::DEPTH_W-1:0] depth_mem [MAX_WIDTH * MAX_HEIGHT];
	logic [trd_pkg::COLOR_W-1:0] color_mem [MAX_WIDTH * MAX_HEIGHT];
	logic [trd_pkg::DEPTH_W-1:0] rd_depth_q;
	logic [trd_pkg::COLOR_W-1:0] rd_color_q;

	logic signed [EW-1:0] da_u, da_v, db_u, db_v;
	logic signed [SW-1:0] ab_sum;
	logic in_tri, hit, mem_we, last_v, last_u, take;

	always_comb begin
		da_u = EW'(cmd_q.e2y) <<< F;
		da_v = -(EW'(cmd_q.e2x) <<< F);
		db_u = -(EW'(cmd_q.e1y) <<< F);
		db_v = EW'(cmd_q.e1x) <<< F;
		ab_sum = SW'(a_q) + SW'(b_q);
		if (cmd_q.area > 0) begin
			in_tri = (a_q >= 0) && (b_q >= 0) && (ab_sum <= SW'(cmd_q.area));
		end else begin
			in_tri = (a_q <= 0) && (b_q <= 0) && (ab_sum >= SW'(cmd_q.area));
		end
		hit = in_tri && (cmd_q.depth > $signed(rd_depth_q));
		last_v = (v_q == cmd_q.v_end);
		last_u = (u_q == cmd_q.u_end);
		mem_we = (state_q == trd_pkg::B_WRITE) || (state_q == trd_pkg::B_CHK && hit);
		take = cmd_valid && cmd_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			trd_pkg::B_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						trd_pkg::CMD_DRAW: state_d = trd_pkg::B_PIX;
						trd_pkg::CMD_WRITE: state_d = trd_pkg::B_WRITE;
						trd_pkg::CMD_READ: state_d = trd_pkg::B_RWAIT;
						default: state_d = trd_pkg::B_DONE;
					endcase
				end
			end
			trd_pkg::B_WRITE: state_d = trd_pkg::B_DONE;
			trd_pkg::B_RWAIT: state_d = trd_pkg::B_RDATA;
			trd_pkg::B_RDATA: state_d = trd_pkg::B_DONE;
			trd_pkg::B_PIX: state_d = trd_pkg::B_CHK;
			trd_pkg::B_CHK: begin
				if (last_v && last_u) state_d = trd_pkg::B_DONE;
				else state_d = trd_pkg::B_PIX;
			end
			trd_pkg::B_DONE: begin
				if (res_ready) state_d = trd_pkg::B_IDLE;
			end
			default: state_d = trd_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == trd_pkg::B_IDLE);
		res_valid = (state_q == trd_pkg::B_DONE);
		res.read_depth = rdep_q;
		res.read_color = rcol_q;
		res.pixels_written = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trd_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk: rows inside a column, columns left to right. Edge values and the
	// store address step by additions only.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
			u_q <= cmd.u_start;
			v_q <= cmd.v_start;
			addr_q <= cmd.addr[AW-1:0];
			col_addr_q <= cmd.addr[AW-1:0];
			a_q <= cmd.edge_a;
			b_q <= cmd.edge_b;
			acol_q <= cmd.edge_a;
			bcol_q <= cmd.edge_b;
			cnt_q <= '0;
			rdep_q <= '0;
			rcol_q <= '0;
		end
		if (state_q == trd_pkg::B_RDATA) begin
			rdep_q <= $signed(rd_depth_q);
			rcol_q <= rd_color_q;
		end
		if (state_q == trd_pkg::B_CHK) begin
			if (hit && cnt_q != trd_pkg::COUNT_MAX) cnt_q <= cnt_q + trd_pkg::COUNT_W'(1);
			if (!last_v) begin
				v_q <= v_q + trd_pkg::POS_W'(1);
				addr_q <= addr_q + AW'(width_eff);
				a_q <= a_q + da_v;
				b_q <= b_q + db_v;
			end else if (!last_u) begin
				u_q <= u_q + trd_pkg::POS_W'(1);
				v_q <= cmd_q.v_start;
				col_addr_q <= col_addr_q + AW'(1);
				addr_q <= col_addr_q + AW'(1);
				acol_q <= acol_q + da_u;
				bcol_q <= bcol_q + db_u;
				a_q <= acol_q + da_u;
				b_q <= bcol_q + db_u;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			depth_mem[addr_q] <= cmd_q.depth;
			color_mem[addr_q] <= cmd_q.color;
		end
		rd_depth_q <= depth_mem[addr_q];
		rd_color_q <= color_mem[addr_q];
	end

endmodule

`default_nettype wire

// ----- rtl/core/triangle_raster_depth_test.sv -----
// Pixel write, pixel read and no-op words: F_BOX and F_PUSH, the queue, then
// B_WRITE (write), B_RWAIT and B_RDATA (read) or straight to B_DONE (no-op).
// Draw words: set-up in the front end, one shared multiplier, then B_PIX and
// B_CHK for every pixel of the clamped bounding box (store read, test).
// Set-up of the next word overlaps the walk of the previous one.
// Reset (arst_n low, asynchronous) empties all queues and restores frame size
// to 256 x 256 clamped to the maximum; the depth and colour stores keep contents.
`timescale 1ns / 1ps
`default_nettype none

module triangle_raster_depth_test #(
	parameter int MAX_WIDTH = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int COORD_FRAC_BITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire trd_pkg::in_word_t in_word,
	output logic empty,
	input wire logic pop,
	output trd_pkg::out_word_t out_word,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [trd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [trd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam logic [WW-1:0] RST_W = WW'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
	localparam logic [HW-1:0] RST_H = HW'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

	// Frame size is held already clamped, so that zero acts as one and an
	// oversized value acts as the maximum.
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_W;
			height_q <= RST_H;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == trd_pkg::CFG_WIDTH) begin
				if (cfg_data == '0) width_q <= WW'(1);
				else if (32'(cfg_data) > MAX_WIDTH) width_q <= WW'(MAX_WIDTH);
				else width_q <= WW'(cfg_data);
			end else if (cfg_index == trd_pkg::CFG_HEIGHT) begin
				if (cfg_data == '0) height_q <= HW'(1);
				else if (32'(cfg_data) > MAX_HEIGHT) height_q <= HW'(MAX_HEIGHT);
				else height_q <= HW'(cfg_data);
			end
		end
	end

	// The front end takes one word, works out its bounding box, edge values
	// and store address, and hands a command to the queue.
	logic fq_valid, fq_ready, qb_valid, qb_ready;
	trd_pkg::cmd_t fq_cmd, qb_cmd;

	trd_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.width_eff(width_q),
		.height_eff(height_q),
		.cmd_valid(fq_valid),
		.cmd_ready(fq_ready),
		.cmd(fq_cmd)
	);

	trd_queue #(
		.DEPTH(2)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_data(fq_cmd),
		.rd_valid(qb_valid),
		.rd_ready(qb_ready),
		.rd_data(qb_cmd)
	);

	// The back end owns both stores and walks the box one pixel at a time.
	logic res_valid, res_ready;
	trd_pkg::out_word_t res;

	trd_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(qb_valid),
		.cmd_ready(qb_ready),
		.cmd(qb_cmd),
		.width_eff(width_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Result register: one word waits here for pop while the back end
	// already moves on to the next command.
	logic out_valid_q;
	trd_pkg::out_word_t out_q;

	assign res_ready = !out_valid_q || pop;
	assign empty = !out_valid_q;
	assign out_word = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	// An accepted word always makes the front end busy on the next cycle.
	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> full)
		else $error("front end still free after taking a word");

	// A draw count and read data never come together in one result.
	a_res_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.pixels_written != '0) |->
		(res.read_depth == '0 && res.read_color == '0))
		else $error("result mixes draw count and read data");

	// A result handed over is visible at the output on the next cycle.
	a_res_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> !empty)
		else $error("result lost on the way to the output register");

endmodule

`default_nettype wire
